FILE: sv/espg_pkg.sv
// Shared types and constants for the edge sample point generator.
// Used by espg_ctrl, espg_dp and edge_sample_point_generator_core. No dependencies.
package espg_pkg;

  // Field widths
  localparam int COORD_W   = 11;
  localparam int POS_W     = 13;   // signed walk position, covers -2047..4094
  localparam int CFG_IDX_W = 2;
  localparam int IN_DATA_W  = 48;  // 44 bits of fields, padded to bytes
  localparam int OUT_DATA_W = 24;  // 22 bits of fields, padded to bytes
  localparam int OUT_USER_W = 2;

  // Defaults
  localparam int DEF_MAX_SAMPLES = 64;
  localparam logic [COORD_W-1:0] RST_MIN_LEN   = 11'd80;
  localparam logic [COORD_W-1:0] RST_START_OFF = 11'd20;
  localparam logic [COORD_W-1:0] RST_STEP      = 11'd40;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_LEN   = 2'd0,
    CFG_START_OFF = 2'd1,
    CFG_STEP      = 2'd2
  } cfg_idx_t;

  // Walk phase along the edge
  typedef enum logic [1:0] {
    PH_UP   = 2'd0,   // from low end up to the center
    PH_DOWN = 2'd1,   // from high end down to just above the center
    PH_ONE  = 2'd2,   // short edge, single center point
    PH_END  = 2'd3
  } phase_t;

  // Controller states
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_INIT1 = 5'b00010,
    ST_COUNT = 5'b00100,
    ST_INIT2 = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_edge;
    logic walk_init;
    logic walk_adv;
    logic cnt_clear;
    logic cnt_inc;
    logic idx_clear;
    logic emit;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic point_ok;
    logic walk_done;
    logic cnt_zero;
    logic cnt_full;
    logic last_hit;
    logic out_free;
  } dp_stat_t;

endpackage

FILE: sv/espg_dp.sv
// Datapath: config registers, edge registers, position walker, counters and output register.
// Depends on espg_pkg; driven by espg_ctrl commands.
module espg_dp import espg_pkg::*; #(
  parameter int MAX_SAMPLES = DEF_MAX_SAMPLES
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration write
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_data,
  // edge fields
  input  logic [COORD_W-1:0]   start_x,
  input  logic [COORD_W-1:0]   start_y,
  input  logic [COORD_W-1:0]   end_x,
  input  logic [COORD_W-1:0]   end_y,
  // control
  input  dp_cmd_t              cmd,
  output dp_stat_t             stat,
  // result register
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [COORD_W-1:0]   sample_x,
  output logic [COORD_W-1:0]   sample_y,
  output logic                 edge_vertical,
  output logic                 last_of_edge,
  output logic                 overflow
);

  localparam int CNT_W = $clog2(MAX_SAMPLES + 2);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SAMPLES);

  // Config registers
  logic [COORD_W-1:0] min_len_r, off_r, step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r <= RST_MIN_LEN;
      off_r     <= RST_START_OFF;
      step_r    <= RST_STEP;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN_LEN:   min_len_r <= cfg_data;
        CFG_START_OFF: off_r     <= cfg_data;
        CFG_STEP:      step_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Edge capture: run axis ends, center, fixed coordinate
  logic               vert_r;
  logic [COORD_W-1:0] fixed_r, lo_r, hi_r, centre_r;
  logic               vert_nxt;
  logic [COORD_W-1:0] ea, eb;
  logic [COORD_W:0]   esum;

  always_comb begin
    vert_nxt = (start_y != end_y);
    ea       = vert_nxt ? start_y : start_x;
    eb       = vert_nxt ? end_y   : end_x;
    esum     = {1'b0, ea} + {1'b0, eb};
  end

  always_ff @(posedge clk) begin
    if (cmd.load_edge) begin
      vert_r   <= vert_nxt;
      fixed_r  <= vert_nxt ? start_x : start_y;
      lo_r     <= (ea < eb) ? ea : eb;
      hi_r     <= (ea < eb) ? eb : ea;
      centre_r <= esum[COORD_W:1];
    end
  end

  // Position walker
  phase_t                   phase_r, phase_nxt;
  logic signed [POS_W-1:0]  pos_r, pos_nxt;
  logic signed [POS_W-1:0]  centre_s, step_s, hi_off_s, lo_off_s;
  logic [COORD_W-1:0]       span;
  logic                     is_short;
  logic                     point_ok;

  always_comb begin
    centre_s = $signed({2'b00, centre_r});
    step_s   = (step_r == '0) ? POS_W'(1) : $signed({2'b00, step_r});
    hi_off_s = $signed({2'b00, hi_r}) - $signed({2'b00, off_r});
    lo_off_s = $signed({2'b00, lo_r}) + $signed({2'b00, off_r});
    span     = hi_r - lo_r;
    is_short = (span <= min_len_r);

    unique case (phase_r)
      PH_UP:   point_ok = (pos_r <= centre_s);
      PH_DOWN: point_ok = (pos_r > centre_s);
      PH_ONE:  point_ok = 1'b1;
      PH_END:  point_ok = 1'b0;
      default: point_ok = 1'b0;
    endcase

    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    if (cmd.walk_init) begin
      phase_nxt = is_short ? PH_ONE : PH_UP;
      pos_nxt   = is_short ? centre_s : lo_off_s;
    end else if (cmd.walk_adv) begin
      unique case (phase_r)
        PH_UP: begin
          if (point_ok) begin
            pos_nxt = pos_r + step_s;
          end else begin
            phase_nxt = PH_DOWN;
            pos_nxt   = hi_off_s;
          end
        end
        PH_DOWN: begin
          if (point_ok) pos_nxt = pos_r - step_s;
          else          phase_nxt = PH_END;
        end
        PH_ONE:  phase_nxt = PH_END;
        PH_END:  phase_nxt = PH_END;
        default: phase_nxt = PH_END;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_END;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
  end

  // Point count (the controller stops it at MAX_SAMPLES + 1) and emit index
  logic [CNT_W-1:0] cnt_r, idx_r, kept;
  logic             ovf;

  always_ff @(posedge clk) begin
    if (cmd.cnt_clear)    cnt_r <= '0;
    else if (cmd.cnt_inc) cnt_r <= cnt_r + CNT_W'(1);
    if (cmd.idx_clear)    idx_r <= '0;
    else if (cmd.emit)    idx_r <= idx_r + CNT_W'(1);
  end

  always_comb begin
    ovf  = (cnt_r > MAX_CNT);
    kept = ovf ? MAX_CNT : cnt_r;
  end

  // Output register
  logic               out_valid_r;
  logic [COORD_W-1:0] sx_r, sy_r;
  logic               vert_o_r, last_r, ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      sx_r     <= vert_r ? fixed_r : pos_r[COORD_W-1:0];
      sy_r     <= vert_r ? pos_r[COORD_W-1:0] : fixed_r;
      vert_o_r <= vert_r;
      last_r   <= (idx_r + CNT_W'(1) == kept);
      ovf_r    <= ovf;
    end
  end

  assign out_valid     = out_valid_r;
  assign sample_x      = sx_r;
  assign sample_y      = sy_r;
  assign edge_vertical = vert_o_r;
  assign last_of_edge  = last_r;
  assign overflow      = ovf_r;

  // Status
  always_comb begin
    stat.point_ok  = point_ok;
    stat.walk_done = (phase_r == PH_END);
    stat.cnt_zero  = (cnt_r == '0);
    stat.cnt_full  = (cnt_r == MAX_CNT);
    stat.last_hit  = (idx_r + CNT_W'(1) == kept);
    stat.out_free  = !out_valid_r || out_ready;
  end

endmodule

FILE: sv/espg_ctrl.sv
// Controller: sequences accept, count pass and emit pass for one edge.
// Depends on espg_pkg; commands espg_dp.
module espg_ctrl import espg_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_edge = 1'b1;
          state_nxt     = ST_INIT1;
        end
      end
      ST_INIT1: begin
        cmd.walk_init = 1'b1;
        cmd.cnt_clear = 1'b1;
        state_nxt     = ST_COUNT;
      end
      // count points, stopping one past the cap
      ST_COUNT: begin
        if (stat.walk_done) begin
          state_nxt = stat.cnt_zero ? ST_IDLE : ST_INIT2;
        end else begin
          cmd.walk_adv = 1'b1;
          if (stat.point_ok) begin
            cmd.cnt_inc = 1'b1;
            if (stat.cnt_full) state_nxt = ST_INIT2;
          end
        end
      end
      ST_INIT2: begin
        cmd.walk_init = 1'b1;
        cmd.idx_clear = 1'b1;
        state_nxt     = ST_EMIT;
      end
      // walk again, one point per free output slot
      ST_EMIT: begin
        if (stat.point_ok) begin
          if (stat.out_free) begin
            cmd.emit     = 1'b1;
            cmd.walk_adv = 1'b1;
            if (stat.last_hit) state_nxt = ST_IDLE;
          end
        end else begin
          cmd.walk_adv = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

FILE: sv/edge_sample_point_generator_core.sv
// Edge sample point generator, top level. Depends on espg_pkg, espg_ctrl, espg_dp.
// An edge is walked twice: a count pass, then an emit pass that outputs its points.
// A new edge is accepted only after the last point of the current edge is emitted
// (or once its count pass finds no points); the count stops at MAX_SAMPLES+1.
// Reset (rst_n low, synchronous): controller idle, output empty, config to 80/20/40.
module edge_sample_point_generator_core import espg_pkg::*; #(
  parameter int MAX_SAMPLES = DEF_MAX_SAMPLES
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // edge input
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // start_x, start_y, end_x, end_y, zero pad
  // sample output
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // sample_x, sample_y, zero pad
  output logic [OUT_USER_W-1:0] out_tuser,  // edge_vertical, overflow
  output logic                  out_tlast,  // last_of_edge
  // configuration write
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [COORD_W-1:0]    cfg_data
);

  dp_cmd_t            cmd;
  dp_stat_t           stat;
  logic [COORD_W-1:0] sample_x, sample_y;
  logic               edge_vertical, overflow;

  assign cfg_ready = 1'b1;

  espg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  espg_dp #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_valid & cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .start_x       (in_tdata[COORD_W-1:0]),
    .start_y       (in_tdata[2*COORD_W-1:COORD_W]),
    .end_x         (in_tdata[3*COORD_W-1:2*COORD_W]),
    .end_y         (in_tdata[4*COORD_W-1:3*COORD_W]),
    .cmd           (cmd),
    .stat          (stat),
    .out_ready     (out_tready),
    .out_valid     (out_tvalid),
    .sample_x      (sample_x),
    .sample_y      (sample_y),
    .edge_vertical (edge_vertical),
    .last_of_edge  (out_tlast),
    .overflow      (overflow)
  );

  // Pack result fields
  assign out_tdata = {{(OUT_DATA_W-2*COORD_W){1'b0}}, sample_y, sample_x};
  assign out_tuser = {overflow, edge_vertical};

endmodule
